[rtl/hpg_pkg.sv]
// types, constants and prime tables shared by the halton point generator
`timescale 1ns / 1ps
`default_nettype none
package hpg_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int COORD_W    = 32;
    localparam int DIM_W      = 3;
    localparam int DIMS_W     = 4;
    localparam int OFF_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int PRIME_W    = 9;
    localparam int ROM_AW     = 6;
    localparam int ROM_DEPTH  = 64;
    localparam int FRAC_W     = COORD_W + PRIME_W;
    localparam int RAW_W      = PRIME_W + 1;
    localparam int BITS_W     = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSIONS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_OFFSET  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_OFFSET = 2'd2;

    typedef logic [3:0] t_op;
    typedef logic [2:0] t_cond;
    typedef logic [3:0] t_step;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step jt;
        t_step jf;
    } t_uop;

    localparam t_op OP_NOP    = 4'd0;
    localparam t_op OP_ACCEPT = 4'd1;
    localparam t_op OP_LOAD   = 4'd2;
    localparam t_op OP_FRINIT = 4'd3;
    localparam t_op OP_MUL    = 4'd4;
    localparam t_op OP_REM    = 4'd5;
    localparam t_op OP_FIX    = 4'd6;
    localparam t_op OP_ACC    = 4'd7;
    localparam t_op OP_DIV    = 4'd8;
    localparam t_op OP_EMIT   = 4'd9;
    localparam t_op OP_NEXT   = 4'd10;

    localparam t_cond C_ALWAYS    = 3'd0;
    localparam t_cond C_IN_REQ    = 3'd1;
    localparam t_cond C_N_ZERO    = 3'd2;
    localparam t_cond C_BITS_DONE = 3'd3;
    localparam t_cond C_OUT_FREE  = 3'd4;
    localparam t_cond C_LAST      = 3'd5;

    localparam t_step S_IDLE = 4'd0;
    localparam t_step S_LOAD = 4'd1;
    localparam t_step S_TEST = 4'd2;
    localparam t_step S_MUL  = 4'd3;
    localparam t_step S_REM  = 4'd4;
    localparam t_step S_FIX  = 4'd5;
    localparam t_step S_ACC  = 4'd6;
    localparam t_step S_FRAC = 4'd7;
    localparam t_step S_EMIT = 4'd8;
    localparam t_step S_NEXT = 4'd9;

    localparam logic [PRIME_W-1:0] PRIME_ROM [ROM_DEPTH] = '{
        9'd2,   9'd3,   9'd5,   9'd7,   9'd11,  9'd13,  9'd17,  9'd19,
        9'd23,  9'd29,  9'd31,  9'd37,  9'd41,  9'd43,  9'd47,  9'd53,
        9'd59,  9'd61,  9'd67,  9'd71,  9'd73,  9'd79,  9'd83,  9'd89,
        9'd97,  9'd101, 9'd103, 9'd107, 9'd109, 9'd113, 9'd127, 9'd131,
        9'd137, 9'd139, 9'd149, 9'd151, 9'd157, 9'd163, 9'd167, 9'd173,
        9'd179, 9'd181, 9'd191, 9'd193, 9'd197, 9'd199, 9'd211, 9'd223,
        9'd227, 9'd229, 9'd233, 9'd239, 9'd241, 9'd251, 9'd257, 9'd263,
        9'd269, 9'd271, 9'd277, 9'd281, 9'd283, 9'd293, 9'd307, 9'd311
    };

    localparam logic [COORD_W:0] TWO_32 = 33'h1_0000_0000;

    // floor(2^32 / p), quotient estimate never above the true quotient
    localparam logic [COORD_W-1:0] RECIP_ROM [ROM_DEPTH] = '{
        32'(TWO_32 / PRIME_ROM[0]),  32'(TWO_32 / PRIME_ROM[1]),
        32'(TWO_32 / PRIME_ROM[2]),  32'(TWO_32 / PRIME_ROM[3]),
        32'(TWO_32 / PRIME_ROM[4]),  32'(TWO_32 / PRIME_ROM[5]),
        32'(TWO_32 / PRIME_ROM[6]),  32'(TWO_32 / PRIME_ROM[7]),
        32'(TWO_32 / PRIME_ROM[8]),  32'(TWO_32 / PRIME_ROM[9]),
        32'(TWO_32 / PRIME_ROM[10]), 32'(TWO_32 / PRIME_ROM[11]),
        32'(TWO_32 / PRIME_ROM[12]), 32'(TWO_32 / PRIME_ROM[13]),
        32'(TWO_32 / PRIME_ROM[14]), 32'(TWO_32 / PRIME_ROM[15]),
        32'(TWO_32 / PRIME_ROM[16]), 32'(TWO_32 / PRIME_ROM[17]),
        32'(TWO_32 / PRIME_ROM[18]), 32'(TWO_32 / PRIME_ROM[19]),
        32'(TWO_32 / PRIME_ROM[20]), 32'(TWO_32 / PRIME_ROM[21]),
        32'(TWO_32 / PRIME_ROM[22]), 32'(TWO_32 / PRIME_ROM[23]),
        32'(TWO_32 / PRIME_ROM[24]), 32'(TWO_32 / PRIME_ROM[25]),
        32'(TWO_32 / PRIME_ROM[26]), 32'(TWO_32 / PRIME_ROM[27]),
        32'(TWO_32 / PRIME_ROM[28]), 32'(TWO_32 / PRIME_ROM[29]),
        32'(TWO_32 / PRIME_ROM[30]), 32'(TWO_32 / PRIME_ROM[31]),
        32'(TWO_32 / PRIME_ROM[32]), 32'(TWO_32 / PRIME_ROM[33]),
        32'(TWO_32 / PRIME_ROM[34]), 32'(TWO_32 / PRIME_ROM[35]),
        32'(TWO_32 / PRIME_ROM[36]), 32'(TWO_32 / PRIME_ROM[37]),
        32'(TWO_32 / PRIME_ROM[38]), 32'(TWO_32 / PRIME_ROM[39]),
        32'(TWO_32 / PRIME_ROM[40]), 32'(TWO_32 / PRIME_ROM[41]),
        32'(TWO_32 / PRIME_ROM[42]), 32'(TWO_32 / PRIME_ROM[43]),
        32'(TWO_32 / PRIME_ROM[44]), 32'(TWO_32 / PRIME_ROM[45]),
        32'(TWO_32 / PRIME_ROM[46]), 32'(TWO_32 / PRIME_ROM[47]),
        32'(TWO_32 / PRIME_ROM[48]), 32'(TWO_32 / PRIME_ROM[49]),
        32'(TWO_32 / PRIME_ROM[50]), 32'(TWO_32 / PRIME_ROM[51]),
        32'(TWO_32 / PRIME_ROM[52]), 32'(TWO_32 / PRIME_ROM[53]),
        32'(TWO_32 / PRIME_ROM[54]), 32'(TWO_32 / PRIME_ROM[55]),
        32'(TWO_32 / PRIME_ROM[56]), 32'(TWO_32 / PRIME_ROM[57]),
        32'(TWO_32 / PRIME_ROM[58]), 32'(TWO_32 / PRIME_ROM[59]),
        32'(TWO_32 / PRIME_ROM[60]), 32'(TWO_32 / PRIME_ROM[61]),
        32'(TWO_32 / PRIME_ROM[62]), 32'(TWO_32 / PRIME_ROM[63])
    };

endpackage
`default_nettype wire

[rtl/hpg_if.sv]
// request channel interfaces: sample input, point output, register writes
`timescale 1ns / 1ps
`default_nettype none
interface hpg_sample_if;
    import hpg_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_index;
    logic                mode;

    modport source (output valid, output sample_index, output mode, input ready);
    modport sink   (input valid, input sample_index, input mode, output ready);
endinterface

interface hpg_point_if;
    import hpg_pkg::*;
    logic               valid;
    logic               ready;
    logic [DIM_W-1:0]   dim_index;
    logic [COORD_W-1:0] coordinate;
    logic               last;

    modport source (output valid, output dim_index, output coordinate, output last,
                    input ready);
    modport sink   (input valid, input dim_index, input coordinate, input last,
                    output ready);
endinterface

interface hpg_cfg_if;
    import hpg_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/halton_point_generator.sv]
// halton point generator: microcoded radical inverse sequencer
`timescale 1ns / 1ps
`default_nettype none
// Each sample request yields one coordinate per active dimension k, the radical
// inverse of the index in prime (offset + k) as a truncated 0.32 fraction, with last
// set on the final one. A small control program steps one shared datapath: per
// dimension a load step, then for each of the m base-p digits of the index a test,
// a reciprocal multiply, a remainder, a correction and an accumulate step, one final
// test, restoring long division to 32 quotient bits, an emit step and a next step
// (m = 0 for index 0, up to 32 in base 2). A sample takes an accept step plus the
// steps of its dimensions; a stalled output holds the emit step. The next request is
// taken once the last coordinate is in the output register and the next step is done.
module halton_point_generator #(
    parameter int MAX_DIMS    = 8,
    parameter int PRIME_COUNT = 32
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    hpg_cfg_if.sink      i_cfg,
    hpg_sample_if.sink   i_sample,
    hpg_point_if.source  o_point
);
    import hpg_pkg::*;

    localparam int K_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int PRIME_LAST = ((PRIME_COUNT > ROM_DEPTH) ? ROM_DEPTH : PRIME_COUNT) - 1;
    localparam logic [ROM_AW-1:0] PRIME_TOP = ROM_AW'(PRIME_LAST);
    localparam logic [DIMS_W:0]   MAX_D     = (DIMS_W + 1)'(MAX_DIMS);

    localparam t_uop UCODE [16] = '{
        '{OP_ACCEPT, C_IN_REQ,    S_LOAD, S_IDLE},
        '{OP_LOAD,   C_ALWAYS,    S_TEST, S_TEST},
        '{OP_FRINIT, C_N_ZERO,    S_FRAC, S_MUL},
        '{OP_MUL,    C_ALWAYS,    S_REM,  S_REM},
        '{OP_REM,    C_ALWAYS,    S_FIX,  S_FIX},
        '{OP_FIX,    C_ALWAYS,    S_ACC,  S_ACC},
        '{OP_ACC,    C_ALWAYS,    S_TEST, S_TEST},
        '{OP_DIV,    C_BITS_DONE, S_EMIT, S_FRAC},
        '{OP_EMIT,   C_OUT_FREE,  S_NEXT, S_EMIT},
        '{OP_NEXT,   C_LAST,      S_IDLE, S_LOAD},
        '{OP_NOP,    C_ALWAYS,    S_IDLE, S_IDLE},
        '{OP_NOP,    C_ALWAYS,    S_IDLE, S_IDLE},
        '{OP_NOP,    C_ALWAYS,    S_IDLE, S_IDLE},
        '{OP_NOP,    C_ALWAYS,    S_IDLE, S_IDLE},
        '{OP_NOP,    C_ALWAYS,    S_IDLE, S_IDLE},
        '{OP_NOP,    C_ALWAYS,    S_IDLE, S_IDLE}
    };

    logic [3:0]            r_upc,   n_upc;
    logic [SAMPLE_W-1:0]   r_idx,   n_idx;
    logic [OFF_W-1:0]      r_off,   n_off;
    logic [K_W-1:0]        r_k,     n_k;
    logic [PRIME_W-1:0]    r_base,  n_base;
    logic [COORD_W-1:0]    r_recip, n_recip;
    logic [SAMPLE_W-1:0]   r_n,     n_n;
    logic [2*COORD_W-1:0]  r_prod,  n_prod;
    logic [COORD_W-1:0]    r_q,     n_q;
    logic [RAW_W-1:0]      r_rraw,  n_rraw;
    logic [PRIME_W-1:0]    r_digit, n_digit;
    logic [FRAC_W-1:0]     r_rev,   n_rev;
    logic [FRAC_W-1:0]     r_den,   n_den;
    logic [FRAC_W-1:0]     r_rem,   n_rem;
    logic [BITS_W-1:0]     r_bits,  n_bits;
    logic                  r_out_valid, n_out_valid;
    logic [DIM_W-1:0]      r_out_dim,   n_out_dim;
    logic [COORD_W-1:0]    r_out_coord, n_out_coord;
    logic                  r_out_last,  n_out_last;
    logic [DIMS_W-1:0]     r_dims;
    logic [OFF_W-1:0]      r_off0;
    logic [OFF_W-1:0]      r_off1;

    t_uop                  w_uop;
    logic                  w_cond;
    logic                  w_out_free;
    logic [DIMS_W:0]       w_dims_eff;
    logic                  w_last;
    logic [ROM_AW-1:0]     w_pidx;
    logic [ROM_AW-1:0]     w_psel;
    logic [FRAC_W-1:0]     w_qp;
    logic [FRAC_W:0]       w_sh;
    logic                  w_ge;

    assign w_uop      = UCODE[r_upc];
    assign w_out_free = !r_out_valid || o_point.ready;

    assign i_cfg.ready    = 1'b1;
    assign i_sample.ready = (w_uop.op == OP_ACCEPT);

    assign o_point.valid      = r_out_valid;
    assign o_point.dim_index  = r_out_dim;
    assign o_point.coordinate = r_out_coord;
    assign o_point.last       = r_out_last;

    always_comb begin
        if (r_dims == '0) begin
            w_dims_eff = (DIMS_W + 1)'(1);
        end else if ({1'b0, r_dims} > MAX_D) begin
            w_dims_eff = MAX_D;
        end else begin
            w_dims_eff = {1'b0, r_dims};
        end
    end

    assign w_last = ((DIMS_W + 1)'(r_k) + (DIMS_W + 1)'(1)) == w_dims_eff;
    assign w_pidx = ROM_AW'(r_off) + ROM_AW'(r_k);
    assign w_psel = (w_pidx > PRIME_TOP) ? PRIME_TOP : w_pidx;
    assign w_qp   = {{PRIME_W{1'b0}}, r_prod[2*COORD_W-1:COORD_W]}
                    * {{COORD_W{1'b0}}, r_base};
    assign w_sh   = {r_rem, 1'b0};
    assign w_ge   = w_sh >= {1'b0, r_den};

    always_comb begin
        unique case (w_uop.cond)
            C_ALWAYS:    w_cond = 1'b1;
            C_IN_REQ:    w_cond = i_sample.valid;
            C_N_ZERO:    w_cond = (r_n == '0);
            C_BITS_DONE: w_cond = &r_bits;
            C_OUT_FREE:  w_cond = w_out_free;
            C_LAST:      w_cond = w_last;
            default:     w_cond = 1'b1;
        endcase
        n_upc = w_cond ? w_uop.jt : w_uop.jf;
    end

    always_comb begin
        n_idx       = r_idx;
        n_off       = r_off;
        n_k         = r_k;
        n_base      = r_base;
        n_recip     = r_recip;
        n_n         = r_n;
        n_prod      = r_prod;
        n_q         = r_q;
        n_rraw      = r_rraw;
        n_digit     = r_digit;
        n_rev       = r_rev;
        n_den       = r_den;
        n_rem       = r_rem;
        n_bits      = r_bits;
        n_out_valid = r_out_valid && !o_point.ready;
        n_out_dim   = r_out_dim;
        n_out_coord = r_out_coord;
        n_out_last  = r_out_last;
        unique case (w_uop.op)
            OP_ACCEPT: begin
                if (i_sample.valid) begin
                    n_idx = i_sample.sample_index;
                    n_off = i_sample.mode ? r_off1 : r_off0;
                    n_k   = '0;
                end
            end
            OP_LOAD: begin
                n_base  = PRIME_ROM[w_psel];
                n_recip = RECIP_ROM[w_psel];
                n_n     = r_idx;
                n_rev   = '0;
                n_den   = FRAC_W'(1);
            end
            OP_FRINIT: begin
                n_rem  = r_rev;
                n_bits = '0;
                n_q    = '0;
            end
            OP_MUL: begin
                n_prod = {{COORD_W{1'b0}}, r_n} * {{SAMPLE_W{1'b0}}, r_recip};
            end
            OP_REM: begin
                n_q    = r_prod[2*COORD_W-1:COORD_W];
                n_rraw = RAW_W'({{PRIME_W{1'b0}}, r_n} - w_qp);
            end
            OP_FIX: begin
                // estimate may be one short of the true quotient
                if (r_rraw >= {1'b0, r_base}) begin
                    n_digit = PRIME_W'(r_rraw - {1'b0, r_base});
                    n_n     = r_q + COORD_W'(1);
                end else begin
                    n_digit = r_rraw[PRIME_W-1:0];
                    n_n     = r_q;
                end
            end
            OP_ACC: begin
                n_rev = FRAC_W'(r_rev * r_base) + FRAC_W'(r_digit);
                n_den = FRAC_W'(r_den * r_base);
            end
            OP_DIV: begin
                n_rem  = w_ge ? FRAC_W'(w_sh - {1'b0, r_den}) : w_sh[FRAC_W-1:0];
                n_q    = {r_q[COORD_W-2:0], w_ge};
                n_bits = r_bits + BITS_W'(1);
            end
            OP_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_dim   = DIM_W'(r_k);
                    n_out_coord = r_q;
                    n_out_last  = w_last;
                end
            end
            OP_NEXT: begin
                n_k = r_k + K_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= S_IDLE;
            r_out_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            r_upc       <= n_upc;
            r_out_valid <= n_out_valid;
            r_k         <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_off       <= n_off;
        r_base      <= n_base;
        r_recip     <= n_recip;
        r_n         <= n_n;
        r_prod      <= n_prod;
        r_q         <= n_q;
        r_rraw      <= n_rraw;
        r_digit     <= n_digit;
        r_rev       <= n_rev;
        r_den       <= n_den;
        r_rem       <= n_rem;
        r_bits      <= n_bits;
        r_out_dim   <= n_out_dim;
        r_out_coord <= n_out_coord;
        r_out_last  <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= DIMS_W'(1);
            r_off0 <= OFF_W'(0);
            r_off1 <= OFF_W'(8);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_DIMENSIONS:    r_dims <= i_cfg.data[DIMS_W-1:0];
                CFG_FIRST_OFFSET:  r_off0 <= i_cfg.data[OFF_W-1:0];
                CFG_SECOND_OFFSET: r_off1 <= i_cfg.data[OFF_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/hpg_checker.sv]
// port checker for the halton point generator and its bind
`timescale 1ns / 1ps
`default_nettype none
module hpg_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [2:0]  i_out_dim,
    input wire [31:0] i_out_coord,
    input wire        i_out_last
);

    // an accepted sample keeps the input closed for at least the load and test steps
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready ##1 !i_in_ready)
        else $error("input reopened too early after a sample request");

    // no new sample while a coordinate of the current one is still pending
    a_no_accept_mid_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_last) |-> !i_in_ready)
        else $error("input open while a sample is unfinished");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_dim) && $stable(i_out_coord)
             && $stable(i_out_last)))
        else $error("stalled coordinate changed");

endmodule

bind halton_point_generator hpg_checker u_hpg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_point.valid),
    .i_out_ready (o_point.ready),
    .i_out_dim   (o_point.dim_index),
    .i_out_coord (o_point.coordinate),
    .i_out_last  (o_point.last)
);
`default_nettype wire
